>>> hw/rtl/i2ccrc_pkg.sv
// Shared types, codes and the CRC-8 byte function for the I2C CRC framer/checker.
package i2ccrc_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd1;

    // Item kinds
    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_RX = 1'b1;

    localparam logic [7:0] CRC_POLY_RESET = 8'h07;
    localparam logic [6:0] ADDR_RESET     = 7'h08;
    localparam logic [7:0] CRC_TOPBIT     = 8'h80;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc;
        logic       status;
        logic       last;
    } result_t;

    // One byte through an MSB-first CRC-8, x^8 implicit in the key.
    function automatic logic [7:0] crc8_byte(input logic [7:0] key,
                                             input logic [7:0] crc,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != 8'h00)
            begin
                c = {c[6:0], 1'b0} ^ key;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/i2c_per_byte_crc8_framer_checker.sv
// Top level: per-byte CRC-8 framer (transmit) and checker (receive) for an I2C link.
//
// Each input item is a transmit byte to frame or a received byte to check.
// Transmit: the register byte that opens a transfer (start_of_transfer high)
// passes through as one result; each data byte gives two results, the byte
// and then its CRC (is_crc high). The first CRC after a register byte covers
// the write address byte, the register and the data; later ones the data only.
// Receive: bytes come as data/CRC pairs; the data byte gives no result, the
// CRC byte gives the held data with status high on mismatch. The first pair of
// a transfer also covers the read address byte. A received start in the middle
// of a pair drops the pending pair. Transmit and receive keep separate state.
// Flow: an accepted item is held in the input register, and its results are
// written into a four-entry result queue once the queue has room for all of
// them; a new item is accepted as the held one is written. The result port
// delivers one result per cycle while result_stall is low. The CRC of the
// address bytes is worked out when a configuration register is written, so
// each item needs only one unrolled 8-bit CRC step.
// The configuration port is always ready; write only while the block is idle.
module i2c_per_byte_crc8_framer_checker
    import i2ccrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // item channel
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   kind,
    input  logic [7:0]             in_byte,
    input  logic                   start_of_transfer,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [7:0]             out_byte,
    output logic                   is_crc,
    output logic                   status,
    output logic                   last,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    // ---------------- configuration ----------------
    logic [7:0] poly_reg, poly_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] waddr_crc_reg, waddr_crc_next;  // CRC of write address byte
    logic [7:0] raddr_crc_reg, raddr_crc_next;  // CRC of read address byte
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        poly_next = poly_reg;
        addr_next = addr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CRC_POLY:       poly_next = cfg_data;
                REG_DEVICE_ADDRESS: addr_next = cfg_data[6:0];
                default:            ;
            endcase
        end
        waddr_crc_next = crc8_byte(poly_next, 8'h00, {addr_next, 1'b0});
        raddr_crc_next = crc8_byte(poly_next, 8'h00, {addr_next, 1'b1});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= CRC_POLY_RESET;
            addr_reg      <= ADDR_RESET;
            waddr_crc_reg <= crc8_byte(CRC_POLY_RESET, 8'h00, {ADDR_RESET, 1'b0});
            raddr_crc_reg <= crc8_byte(CRC_POLY_RESET, 8'h00, {ADDR_RESET, 1'b1});
        end
        else if (cfg_we)
        begin
            poly_reg      <= poly_next;
            addr_reg      <= addr_next;
            waddr_crc_reg <= waddr_crc_next;
            raddr_crc_reg <= raddr_crc_next;
        end
    end

    // ---------------- input register ----------------
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_kind_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       item_accept;
    logic       s1_fire;

    assign item_stall  = s1_valid_reg && !s1_fire;
    assign item_accept = item_valid && !item_stall;

    always_comb
    begin
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_kind_reg  <= kind;
            s1_byte_reg  <= in_byte;
            s1_start_reg <= start_of_transfer;
        end
    end

    // ---------------- framing / checking ----------------
    logic       first_pending_reg, first_pending_next;
    logic [7:0] prefix_crc_reg, prefix_crc_next;
    logic       rx_expect_crc_reg, rx_expect_crc_next;
    logic [7:0] held_data_reg, held_data_next;
    logic [7:0] held_crc_reg, held_crc_next;
    logic [7:0] crc_init;
    logic [7:0] crc_out;
    result_t    res0, res1;
    logic [1:0] push_n;

    always_comb
    begin
        if (s1_kind_reg == KIND_TX)
        begin
            if (s1_start_reg)
            begin
                crc_init = waddr_crc_reg;
            end
            else
            begin
                crc_init = first_pending_reg ? prefix_crc_reg : 8'h00;
            end
        end
        else
        begin
            crc_init = s1_start_reg ? raddr_crc_reg : 8'h00;
        end
    end

    assign crc_out = crc8_byte(poly_reg, crc_init, s1_byte_reg);

    always_comb
    begin
        first_pending_next = first_pending_reg;
        prefix_crc_next    = prefix_crc_reg;
        rx_expect_crc_next = rx_expect_crc_reg;
        held_data_next     = held_data_reg;
        held_crc_next      = held_crc_reg;
        res0   = '{out_byte: s1_byte_reg, is_crc: 1'b0, status: 1'b0, last: 1'b1};
        res1   = '{out_byte: crc_out, is_crc: 1'b1, status: 1'b0, last: 1'b1};
        push_n = 2'd0;
        if (s1_kind_reg == KIND_TX)
        begin
            if (s1_start_reg)
            begin
                // register byte: passes through, loads prefix
                prefix_crc_next    = crc_out;
                first_pending_next = 1'b1;
                push_n             = 2'd1;
            end
            else
            begin
                // data byte then its CRC
                first_pending_next = 1'b0;
                res0.last          = 1'b0;
                push_n             = 2'd2;
            end
        end
        else if (s1_start_reg || !rx_expect_crc_reg)
        begin
            // data half of a pair; a start drops any pending pair
            held_data_next     = s1_byte_reg;
            held_crc_next      = crc_out;
            rx_expect_crc_next = 1'b1;
        end
        else
        begin
            rx_expect_crc_next = 1'b0;
            res0.out_byte      = held_data_reg;
            res0.status        = (s1_byte_reg != held_crc_reg);
            push_n             = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b0;
            prefix_crc_reg    <= 8'h00;
            rx_expect_crc_reg <= 1'b0;
            held_data_reg     <= 8'h00;
            held_crc_reg      <= 8'h00;
        end
        else if (s1_fire)
        begin
            first_pending_reg <= first_pending_next;
            prefix_crc_reg    <= prefix_crc_next;
            rx_expect_crc_reg <= rx_expect_crc_next;
            held_data_reg     <= held_data_next;
            held_crc_reg      <= held_crc_next;
        end
    end

    // ---------------- result queue ----------------
    result_t                queue_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_CNT_W-1:0] free_slots;
    logic [QUEUE_CNT_W-1:0] push_cnt;
    logic                   pop;
    result_t                head;

    assign free_slots = QUEUE_CNT_W'(QUEUE_DEPTH) - count_reg;
    assign s1_fire    = s1_valid_reg && (free_slots >= QUEUE_CNT_W'(push_n));
    assign push_cnt   = s1_fire ? QUEUE_CNT_W'(push_n) : '0;
    assign pop        = result_valid && !result_stall;

    assign wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign count_next  = count_reg + push_cnt - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == QUEUE_CNT_W'(2))
        begin
            queue_mem[wr_ptr_reg + QUEUE_PTR_W'(1)] <= res1;
        end
    end

    assign head         = queue_mem[rd_ptr_reg];
    assign result_valid = (count_reg != '0);
    assign out_byte     = head.out_byte;
    assign is_crc       = head.is_crc;
    assign status       = head.status;
    assign last         = head.last;

endmodule
